>>> src/acmo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the audio channel mix operation block.
// No dependencies; used by the channel interfaces and the top level.
package acmo_pkg;

  // Fixed frame geometry
  localparam int LANES      = 8;
  localparam int SMP_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 12;
  localparam int CNT_W      = 4;

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]        chan_cnt_t;

  // Operation codes held in the operation register
  typedef enum logic [2:0] {
    OP_SWAP     = 3'd0,
    OP_ADD      = 3'd1,
    OP_VOLUME   = 3'd2,
    OP_LIMIT    = 3'd3,
    OP_INSERT   = 3'd4,
    OP_DROP     = 3'd5,
    OP_TRUNCATE = 3'd6
  } op_code_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_OPERATION = 3'd0,
    REG_TARGET    = 3'd1,
    REG_SOURCE    = 3'd2,
    REG_GAIN      = 3'd3,
    REG_FORMAT    = 3'd4,
    REG_COUNT     = 3'd5
  } reg_idx_t;

  // Full-scale bounds for the limit operation, Q16.16
  localparam logic signed [32:0] FS_PCM_HI = 33'sd2147418112;
  localparam logic signed [32:0] FS_PCM_LO = -33'sd2147483648;
  localparam logic signed [32:0] FS_FLT_HI = 33'sd65536;
  localparam logic signed [32:0] FS_FLT_LO = -33'sd65536;

endpackage

>>> src/acmo_in_if.sv
`timescale 1ns / 1ps
// Input frame channel: valid/ready handshake carrying one interleaved frame.
// Depends on acmo_pkg for the sample type.
interface acmo_in_if;
  import acmo_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  sample_t sample_4;
  sample_t sample_5;
  sample_t sample_6;
  sample_t sample_7;
  logic    last_frame;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7, last_frame,
    input  ready
  );

  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7, last_frame,
    output ready
  );
endinterface

>>> src/acmo_out_if.sv
`timescale 1ns / 1ps
// Result frame channel: valid/ready handshake carrying one processed frame.
// Depends on acmo_pkg for the sample and channel count types.
interface acmo_out_if;
  import acmo_pkg::*;

  logic      valid;
  logic      ready;
  sample_t   out_0;
  sample_t   out_1;
  sample_t   out_2;
  sample_t   out_3;
  sample_t   out_4;
  sample_t   out_5;
  sample_t   out_6;
  sample_t   out_7;
  chan_cnt_t channels_out;
  logic      bad_request;
  logic      last_out;

  modport source (
    output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
           channels_out, bad_request, last_out,
    input  ready
  );

  modport sink (
    input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
           channels_out, bad_request, last_out,
    output ready
  );
endinterface

>>> src/audio_channel_mix_op_unit.sv
`timescale 1ns / 1ps
// Top level of the audio channel mix operation block.
// Depends on acmo_pkg, acmo_in_if and acmo_out_if.
//
//  Channel   Direction  Handshake          Beat contents
//  in_ch     in         valid/ready        eight Q16.16 samples, last_frame
//  out_ch    out        valid/ready        eight Q16.16 samples, count, error, last
//  APB       in         psel/penable       one 32-bit register write or read
//
// One frame per cycle is taken while the pipeline is not stalled; an accepted beat
// passes through the input register, then the result register.
// The work between the two registers is one 32x17 multiply per lane, plus one add
// for the add operation and saturation for add and volume, all done in a single pass.
// Reset (rst_n, synchronous) empties both stages and loads the register defaults.
// When the result is stalled, the input register still takes a beat while it is
// empty; the pipeline then holds both frames until the sink takes the result.
module audio_channel_mix_op_unit #(
  parameter int CHAN_LIMIT   = 8,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  acmo_in_if.sink             in_ch,
  acmo_out_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import acmo_pkg::*;

  localparam chan_cnt_t MAX_CH = CNT_W'(CHAN_LIMIT);
  localparam logic signed [48:0] SAT_HI = (49'sd1 <<< (SAMPLE_WIDTH - 1)) - 49'sd1;
  localparam logic signed [48:0] SAT_LO = -SAT_HI - 49'sd1;

  // Configuration registers
  op_code_t         op_r;
  logic [4:0]       tgt_r;
  logic [2:0]       src_r;
  logic [GAIN_W-1:0] gain_r;
  logic             fmt_r;
  chan_cnt_t        cnt_r;

  // Pipeline registers
  logic    s1_valid_r;
  sample_t s1_smp_r [LANES];
  logic    s1_last_r;
  logic    out_valid_r;
  sample_t out_smp_r [LANES];
  chan_cnt_t out_nout_r;
  logic    out_bad_r;
  logic    out_last_r;

  logic s2_ready;
  logic in_acc;
  logic s1_move;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  // Datapath signals
  logic signed [48:0] prod [LANES];
  logic signed [35:0] scl  [LANES];
  logic signed [49:0] lim_hi_prod;
  logic signed [49:0] lim_lo_prod;
  logic signed [35:0] lim_hi;
  logic signed [35:0] lim_lo;
  logic signed [32:0] fs_hi;
  logic signed [32:0] fs_lo;
  logic signed [36:0] add_sum;
  sample_t   y     [LANES];
  sample_t   res   [LANES];
  chan_cnt_t n_eff;
  chan_cnt_t nout;
  logic      err;
  logic      cnt_bad;
  logic      t_neg;
  logic      t_all;
  logic [3:0] t_mag;
  logic      t_lt_n;
  logic      t_le_n;
  logic      s_lt_n;

  // Saturate to the configured sample width, then keep the low 32 bits.
  function automatic sample_t sat_w(input logic signed [36:0] v);
    logic signed [48:0] w;
    w = 49'(v);
    if (w > SAT_HI) begin
      w = SAT_HI;
    end else if (w < SAT_LO) begin
      w = SAT_LO;
    end
    return w[SMP_W-1:0];
  endfunction

  // APB port: writes complete in the access phase, no wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_VOLUME;
      tgt_r  <= 5'h1f;
      src_r  <= 3'd0;
      gain_r <= 16'd4096;
      fmt_r  <= 1'b0;
      cnt_r  <= 4'd2;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OPERATION: op_r   <= op_code_t'(pwdata[2:0]);
        REG_TARGET:    tgt_r  <= pwdata[4:0];
        REG_SOURCE:    src_r  <= pwdata[2:0];
        REG_GAIN:      gain_r <= pwdata[GAIN_W-1:0];
        REG_FORMAT:    fmt_r  <= pwdata[0];
        REG_COUNT:     cnt_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_OPERATION: prdata = {29'd0, op_r};
      REG_TARGET:    prdata = {{27{tgt_r[4]}}, tgt_r};
      REG_SOURCE:    prdata = {29'd0, src_r};
      REG_GAIN:      prdata = {16'd0, gain_r};
      REG_FORMAT:    prdata = {31'd0, fmt_r};
      REG_COUNT:     prdata = {28'd0, cnt_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Handshake: the result register frees the input register, which frees the port
  assign s2_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s2_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_move     = s1_valid_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s2_ready) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register: capture a frame beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_smp_r[0] <= in_ch.sample_0;
      s1_smp_r[1] <= in_ch.sample_1;
      s1_smp_r[2] <= in_ch.sample_2;
      s1_smp_r[3] <= in_ch.sample_3;
      s1_smp_r[4] <= in_ch.sample_4;
      s1_smp_r[5] <= in_ch.sample_5;
      s1_smp_r[6] <= in_ch.sample_6;
      s1_smp_r[7] <= in_ch.sample_7;
      s1_last_r   <= in_ch.last_frame;
    end
  end

  // One gain multiply per lane, low twelve bits dropped (floor)
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod[i] = s1_smp_r[i] * $signed({1'b0, gain_r});
      scl[i]  = prod[i][47:GAIN_SHIFT];
    end
  end

  // Limit bounds: full scale for the sample format, scaled by the gain
  always_comb begin
    fs_hi       = fmt_r ? FS_FLT_HI : FS_PCM_HI;
    fs_lo       = fmt_r ? FS_FLT_LO : FS_PCM_LO;
    lim_hi_prod = fs_hi * $signed({1'b0, gain_r});
    lim_lo_prod = fs_lo * $signed({1'b0, gain_r});
    lim_hi      = lim_hi_prod[47:GAIN_SHIFT];
    lim_lo      = lim_lo_prod[47:GAIN_SHIFT];
  end

  // Channel index checks against the effective channel count
  always_comb begin
    n_eff   = (cnt_r > MAX_CH) ? MAX_CH : cnt_r;
    cnt_bad = (cnt_r == '0) || (cnt_r > MAX_CH);
    t_neg   = tgt_r[4];
    t_all   = (tgt_r == 5'h1f);
    t_mag   = tgt_r[3:0];
    t_lt_n  = !t_neg && (t_mag < n_eff);
    t_le_n  = !t_neg && (t_mag <= n_eff);
    s_lt_n  = ({1'b0, src_r} < n_eff);
    add_sum = 37'(s1_smp_r[tgt_r[2:0]]) + 37'(scl[src_r]);
  end

  // Operation decode and lane selection
  always_comb begin
    err  = cnt_bad;
    nout = n_eff;
    for (int i = 0; i < LANES; i++) begin
      y[i] = s1_smp_r[i];
    end
    if (!cnt_bad) begin
      unique case (op_r)
        OP_SWAP: begin
          if (!(t_lt_n && s_lt_n)) begin
            err = 1'b1;
          end
          for (int i = 0; i < LANES; i++) begin
            if (4'(i) == t_mag) begin
              y[i] = s1_smp_r[src_r];
            end else if (3'(i) == src_r) begin
              y[i] = s1_smp_r[tgt_r[2:0]];
            end
          end
        end
        OP_ADD: begin
          if (!(t_lt_n && s_lt_n)) begin
            err = 1'b1;
          end
          for (int i = 0; i < LANES; i++) begin
            if (4'(i) == t_mag) begin
              y[i] = sat_w(add_sum);
            end
          end
        end
        OP_VOLUME: begin
          if (!(t_all || t_lt_n)) begin
            err = 1'b1;
          end
          for (int i = 0; i < LANES; i++) begin
            if (t_neg || 4'(i) == t_mag) begin
              y[i] = sat_w(37'(scl[i]));
            end
          end
        end
        OP_LIMIT: begin
          if (!(t_all || t_lt_n)) begin
            err = 1'b1;
          end
          for (int i = 0; i < LANES; i++) begin
            if (t_neg || 4'(i) == t_mag) begin
              if (36'(s1_smp_r[i]) > lim_hi) begin
                y[i] = lim_hi[SMP_W-1:0];
              end else if (36'(s1_smp_r[i]) < lim_lo) begin
                y[i] = lim_lo[SMP_W-1:0];
              end
            end
          end
        end
        OP_INSERT: begin
          if (n_eff >= MAX_CH || !t_le_n) begin
            err = 1'b1;
          end
          nout = n_eff + 4'd1;
          for (int i = 0; i < LANES; i++) begin
            if (4'(i) == t_mag) begin
              y[i] = '0;
            end else if (i > 0 && 4'(i) > t_mag) begin
              y[i] = s1_smp_r[(i > 0) ? i - 1 : 0];
            end
          end
        end
        OP_DROP: begin
          if (!t_lt_n) begin
            err = 1'b1;
          end
          nout = n_eff - 4'd1;
          for (int i = 0; i < LANES - 1; i++) begin
            if (4'(i) >= t_mag) begin
              y[i] = s1_smp_r[i + 1];
            end
          end
        end
        OP_TRUNCATE: begin
          if (!t_le_n) begin
            err = 1'b1;
          end
          nout = t_mag;
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
    // A rejected request passes the frame through unchanged
    if (err) begin
      nout = n_eff;
      for (int i = 0; i < LANES; i++) begin
        y[i] = s1_smp_r[i];
      end
    end
    // Lanes beyond the result count read as zero
    for (int i = 0; i < LANES; i++) begin
      res[i] = (4'(i) < nout) ? y[i] : '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int i = 0; i < LANES; i++) begin
        out_smp_r[i] <= res[i];
      end
      out_nout_r <= nout;
      out_bad_r  <= err;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_0        = out_smp_r[0];
  assign out_ch.out_1        = out_smp_r[1];
  assign out_ch.out_2        = out_smp_r[2];
  assign out_ch.out_3        = out_smp_r[3];
  assign out_ch.out_4        = out_smp_r[4];
  assign out_ch.out_5        = out_smp_r[5];
  assign out_ch.out_6        = out_smp_r[6];
  assign out_ch.out_7        = out_smp_r[7];
  assign out_ch.channels_out = out_nout_r;
  assign out_ch.bad_request  = out_bad_r;
  assign out_ch.last_out     = out_last_r;

`ifndef SYNTHESIS
  // The result never claims more channels than the block supports.
  a_nout_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_nout_r <= MAX_CH)
    else $error("channels_out above the channel limit");

  // The top lane is silent whenever the result is narrower than a full frame.
  a_top_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nout_r < 4'd8 |-> out_smp_r[LANES-1] == '0)
    else $error("unused lane carries data");

  // A frame waiting in the input register is kept while the result is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r)
    else $error("frame lost from input register");

  // A rejected request with an in-range count reports that channel count.
  a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r && cnt_r <= MAX_CH |-> out_nout_r == cnt_r)
    else $error("rejected frame with wrong channel count");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for audio_channel_mix_op_unit: a table of directed frames, then
// random frames under random settings, with random idling on both channels.
// Depends on acmo_pkg, acmo_in_if, acmo_out_if and the top level RTL.
module tb_top;
  import acmo_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_BEATS = 900;
  localparam int          PRINT_LIMIT  = 40;
  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam longint      PCM_TOP      = 64'sd2147418112;
  localparam longint      PCM_BOTTOM   = -64'sd2147483648;
  localparam longint      FLT_TOP      = 64'sd65536;
  localparam longint      FLT_BOTTOM   = -64'sd65536;

  typedef logic [LANES-1:0][SMP_W-1:0] lanes_t;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [4:0] tgt;
    logic [2:0]        src;
    logic [15:0]       gain;
    logic              fmt;
    logic [3:0]        cnt;
  } mix_settings_t;

  typedef struct packed {
    lanes_t    lanes;
    chan_cnt_t nout;
    logic      bad;
    logic      last;
  } mix_result_t;

  typedef struct packed {
    mix_settings_t settings;
    lanes_t        samples;
    logic          last;
    logic          typed;
    mix_result_t   result;
  } frame_row_t;

  localparam mix_settings_t RESET_SETTINGS = '{OP_VOLUME, -5'sd1, 3'd0, 16'd4096, 1'b0, 4'd2};

  // Reference frame: half, one, minus one, both extremes, and some odd values.
  localparam lanes_t FRAME_A = {32'h0000_0007, 32'hFFF0_0000, 32'h0012_3456, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000};
  localparam lanes_t FRAME_X = {{6{32'hFFFF_FFFF}}, 32'h8000_0000, 32'h7FFF_FFFF};
  localparam lanes_t A_LOW4  = {{4{32'h0}}, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000,
                                32'h0000_8000};
  localparam lanes_t A_LOW3  = {{5{32'h0}}, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000};

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  acmo_in_if  in_bus ();
  acmo_out_if out_bus ();

  audio_channel_mix_op_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mix_settings_t live_settings = RESET_SETTINGS;
  mix_result_t   pending_results[$];
  frame_row_t    frame_table[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            steady = 1'b0;

  // Clock generation.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Q4.12 product with the low bits dropped, which rounds towards minus infinity.
  function automatic longint scale_q412(longint v, longint g);
    return (v * g) >>> GAIN_SHIFT;
  endfunction

  function automatic longint sat_sample(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Works out the result frame for one input frame under the given settings.
  function automatic mix_result_t predict_frame(mix_settings_t c, lanes_t x, logic lst);
    mix_result_t r;
    longint      xs[LANES];
    longint      y[LANES];
    longint      hi;
    longint      lo;
    int          n;
    int          t;
    int          s;
    int          nout;
    int          k;
    bit          err;
    for (int i = 0; i < LANES; i++) begin
      xs[i] = longint'($signed(x[i]));
      y[i]  = 0;
    end
    n    = (c.cnt > LANES) ? LANES : int'(c.cnt);
    t    = int'($signed(c.tgt));
    s    = int'(c.src);
    err  = (c.cnt == 0) || (c.cnt > LANES);
    nout = n;
    for (int i = 0; i < n; i++) y[i] = xs[i];

    if (!err) begin
      case (c.op)
        OP_SWAP: begin
          if (t < 0 || t >= n || s >= n) err = 1'b1;
          else begin
            y[t] = xs[s];
            y[s] = xs[t];
          end
        end
        OP_ADD: begin
          if (t < 0 || t >= n || s >= n) err = 1'b1;
          else y[t] = sat_sample(xs[t] + scale_q412(xs[s], c.gain));
        end
        OP_VOLUME: begin
          if (t < -1 || t >= n) err = 1'b1;
          else begin
            for (int i = 0; i < n; i++)
              if (t < 0 || i == t) y[i] = sat_sample(scale_q412(xs[i], c.gain));
          end
        end
        OP_LIMIT: begin
          hi = scale_q412(c.fmt ? FLT_TOP : PCM_TOP, c.gain);
          lo = scale_q412(c.fmt ? FLT_BOTTOM : PCM_BOTTOM, c.gain);
          if (t < -1 || t >= n) err = 1'b1;
          else begin
            for (int i = 0; i < n; i++)
              if (t < 0 || i == t) y[i] = (xs[i] > hi) ? hi : ((xs[i] < lo) ? lo : xs[i]);
          end
        end
        OP_INSERT: begin
          if (n >= LANES || t < 0 || t > n) err = 1'b1;
          else begin
            k = 0;
            for (int i = 0; i <= n; i++) begin
              if (i == t) y[i] = 0;
              else begin
                y[i] = xs[k];
                k++;
              end
            end
            nout = n + 1;
          end
        end
        OP_DROP: begin
          if (t < 0 || t >= n) err = 1'b1;
          else begin
            for (int i = t; i < n - 1; i++) y[i] = xs[i + 1];
            y[n - 1] = 0;
            nout = n - 1;
          end
        end
        OP_TRUNCATE: begin
          if (t < 0 || t > n) err = 1'b1;
          else begin
            for (int i = t; i < n; i++) y[i] = 0;
            nout = t;
          end
        end
        default: err = 1'b1;
      endcase
    end

    // A rejected request passes the present lanes through untouched.
    if (err) begin
      nout = n;
      for (int i = 0; i < LANES; i++) y[i] = (i < n) ? xs[i] : 0;
    end
    for (int i = 0; i < LANES; i++) r.lanes[i] = (i < nout) ? 32'(y[i]) : 32'h0;
    r.nout = chan_cnt_t'(nout);
    r.bad  = err;
    r.last = lst;
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'(int'($urandom_range(0, 131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  // Settings mostly in range for the chosen operation, with some of anything the
  // register widths allow.
  function automatic mix_settings_t random_settings();
    mix_settings_t c;
    int            n;
    c.cnt = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
    c.op  = ($urandom_range(0, 99) < 6) ? OP_UNUSED : 3'($urandom_range(0, 6));
    n     = (c.cnt > LANES) ? LANES : int'(c.cnt);
    if ($urandom_range(0, 99) < 15) c.tgt = 5'($urandom_range(0, 31));
    else begin
      case (c.op)
        OP_VOLUME, OP_LIMIT:   c.tgt = 5'(int'($urandom_range(0, n)) - 1);
        OP_INSERT, OP_TRUNCATE: c.tgt = 5'($urandom_range(0, n));
        default:               c.tgt = (n > 0) ? 5'($urandom_range(0, n - 1)) : 5'd0;
      endcase
    end
    if ($urandom_range(0, 99) < 85 && n > 0) c.src = 3'($urandom_range(0, n - 1));
    else c.src = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0:       c.gain = 16'd4096;
      1:       c.gain = 16'd0;
      2:       c.gain = 16'hFFFF;
      3:       c.gain = 16'($urandom_range(0, 8192));
      default: c.gain = 16'($urandom);
    endcase
    c.fmt = 1'($urandom);
    return c;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %08h expected %08h", $realtime, what, got, want);
  endtask

  task automatic push_row(mix_settings_t c, lanes_t x, logic lst, logic typed,
                          lanes_t want_lanes, chan_cnt_t want_n, logic want_bad);
    frame_row_t row;
    row.settings = c;
    row.samples  = x;
    row.last     = lst;
    row.typed    = typed;
    row.result   = '{want_lanes, want_n, want_bad, lst};
    frame_table.push_back(row);
  endtask

  // Stops the input side and waits until every result is back and the pipe is quiet.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all six registers, each with a setup phase and an access phase.
  task automatic program_settings(mix_settings_t c);
    reg_idx_t    idx;
    logic [31:0] v;
    for (int i = 0; i <= int'(REG_COUNT); i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_OPERATION: v = 32'(c.op);
        REG_TARGET:    v = 32'(c.tgt);
        REG_SOURCE:    v = 32'(c.src);
        REG_GAIN:      v = 32'(c.gain);
        REG_FORMAT:    v = 32'(c.fmt);
        default:       v = 32'(c.cnt);
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= v;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel          <= 1'b0;
    penable       <= 1'b0;
    live_settings  = c;
  endtask

  // Offers one frame after a random gap and books its result once the beat is taken.
  task automatic send_frame(lanes_t x, logic lst, mix_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.sample_0   <= x[0];
    in_bus.sample_1   <= x[1];
    in_bus.sample_2   <= x[2];
    in_bus.sample_3   <= x[3];
    in_bus.sample_4   <= x[4];
    in_bus.sample_5   <= x[5];
    in_bus.sample_6   <= x[6];
    in_bus.sample_7   <= x[7];
    in_bus.last_frame <= lst;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(want);
  endtask

  // Result side back-pressure.
  initial begin : result_stall
    int n;
    out_bus.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (steady) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_bus.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Compares every accepted result beat with the oldest booked result.
  always @(posedge clk) begin : result_check
    mix_result_t got;
    mix_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.lanes = {out_bus.out_7, out_bus.out_6, out_bus.out_5, out_bus.out_4,
                   out_bus.out_3, out_bus.out_2, out_bus.out_1, out_bus.out_0};
      got.nout  = out_bus.channels_out;
      got.bad   = out_bus.bad_request;
      got.last  = out_bus.last_out;
      if (pending_results.size() == 0) note_mismatch("unbooked result beat", 32'h0, 32'h0);
      else begin
        want = pending_results.pop_front();
        for (int i = 0; i < LANES; i++)
          if (got.lanes[i] !== want.lanes[i])
            note_mismatch($sformatf("out_%0d", i), got.lanes[i], want.lanes[i]);
        if (got.nout !== want.nout) note_mismatch("channels_out", 32'(got.nout), 32'(want.nout));
        if (got.bad !== want.bad) note_mismatch("bad_request", 32'(got.bad), 32'(want.bad));
        if (got.last !== want.last) note_mismatch("last_out", 32'(got.last), 32'(want.last));
      end
    end
  end

  initial begin : stimulus
    frame_row_t    row;
    mix_settings_t c;
    mix_result_t   want;
    lanes_t        x;
    logic          lst;
    int            beats_left;
    int            seg;

    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b1;
    paddr             = '0;
    pwdata            = '0;
    in_bus.valid      = 1'b0;
    in_bus.sample_0   = '0;
    in_bus.sample_1   = '0;
    in_bus.sample_2   = '0;
    in_bus.sample_3   = '0;
    in_bus.sample_4   = '0;
    in_bus.sample_5   = '0;
    in_bus.sample_6   = '0;
    in_bus.sample_7   = '0;
    in_bus.last_frame = 1'b0;

    // Directed frames. Rows marked typed carry their result; the rest use the predictor.
    // Register defaults straight after reset: unity volume over two channels.
    push_row(RESET_SETTINGS, FRAME_A, 1'b0, 1'b1, {{6{32'h0}}, 32'h0001_0000, 32'h0000_8000},
             4'd2, 1'b0);
    push_row(RESET_SETTINGS, FRAME_X, 1'b1, 1'b1, {{6{32'h0}}, 32'h8000_0000, 32'h7FFF_FFFF},
             4'd2, 1'b0);
    // Gain extremes and single-lane volume.
    push_row('{OP_VOLUME, -5'sd1, 3'd0, 16'd0, 1'b0, 4'd8}, FRAME_A, 1'b0, 1'b1, '0, 4'd8, 1'b0);
    push_row('{OP_VOLUME, -5'sd1, 3'd0, 16'hFFFF, 1'b0, 4'd8}, FRAME_A, 1'b1, 1'b0, '0, 0, 0);
    push_row('{OP_VOLUME, 5'sd3, 3'd0, 16'd8192, 1'b0, 4'd4}, FRAME_A, 1'b0, 1'b0, '0, 0, 0);
    // Swap across the whole frame, and adds that saturate both ways.
    push_row('{OP_SWAP, 5'sd0, 3'd7, 16'd4096, 1'b0, 4'd8}, FRAME_A, 1'b0, 1'b0, '0, 0, 0);
    push_row('{OP_ADD, 5'sd3, 3'd1, 16'hFFFF, 1'b0, 4'd4}, FRAME_A, 1'b1, 1'b0, '0, 0, 0);
    push_row('{OP_ADD, 5'sd4, 3'd2, 16'hFFFF, 1'b0, 4'd8}, FRAME_A, 1'b0, 1'b0, '0, 0, 0);
    // Limit in both formats.
    push_row('{OP_LIMIT, -5'sd1, 3'd0, 16'd4096, 1'b0, 4'd8}, FRAME_A, 1'b0, 1'b0, '0, 0, 0);
    push_row('{OP_LIMIT, 5'sd2, 3'd0, 16'd2048, 1'b1, 4'd3}, FRAME_A, 1'b1, 1'b0, '0, 0, 0);
    push_row('{OP_LIMIT, -5'sd1, 3'd0, 16'hFFFF, 1'b1, 4'd8}, FRAME_A, 1'b0, 1'b0, '0, 0, 0);
    // Insert at the front, append at the end, and insert into a full frame.
    push_row('{OP_INSERT, 5'sd0, 3'd0, 16'd4096, 1'b0, 4'd3}, FRAME_A, 1'b0, 1'b0, '0, 0, 0);
    push_row('{OP_INSERT, 5'sd7, 3'd0, 16'd4096, 1'b0, 4'd7}, FRAME_A, 1'b1, 1'b0, '0, 0, 0);
    push_row('{OP_INSERT, 5'sd2, 3'd0, 16'd4096, 1'b0, 4'd8}, FRAME_A, 1'b0, 1'b1, FRAME_A,
             4'd8, 1'b1);
    // Dropping the only channel, a middle drop, truncation to nothing and to all.
    push_row('{OP_DROP, 5'sd0, 3'd0, 16'd4096, 1'b0, 4'd1}, FRAME_A, 1'b0, 1'b1, '0, 4'd0, 1'b0);
    push_row('{OP_DROP, 5'sd4, 3'd0, 16'd4096, 1'b0, 4'd8}, FRAME_A, 1'b1, 1'b0, '0, 0, 0);
    push_row('{OP_TRUNCATE, 5'sd0, 3'd0, 16'd4096, 1'b0, 4'd5}, FRAME_A, 1'b0, 1'b1, '0, 4'd0,
             1'b0);
    push_row('{OP_TRUNCATE, 5'sd8, 3'd0, 16'd4096, 1'b0, 4'd8}, FRAME_A, 1'b0, 1'b0, '0, 0, 0);
    // Rejected requests: spare opcode, bad counts, channels out of range.
    push_row('{OP_UNUSED, 5'sd0, 3'd0, 16'd4096, 1'b0, 4'd4}, FRAME_A, 1'b1, 1'b1, A_LOW4, 4'd4,
             1'b1);
    push_row('{OP_VOLUME, -5'sd1, 3'd0, 16'd4096, 1'b0, 4'd0}, FRAME_A, 1'b0, 1'b1, '0, 4'd0,
             1'b1);
    push_row('{OP_SWAP, 5'sd0, 3'd1, 16'd4096, 1'b0, 4'd15}, FRAME_A, 1'b0, 1'b1, FRAME_A, 4'd8,
             1'b1);
    push_row('{OP_SWAP, 5'sd2, 3'd5, 16'd4096, 1'b0, 4'd4}, FRAME_A, 1'b1, 1'b1, A_LOW4, 4'd4,
             1'b1);
    push_row('{OP_VOLUME, -5'sd2, 3'd0, 16'd4096, 1'b0, 4'd8}, FRAME_A, 1'b0, 1'b1, FRAME_A, 4'd8,
             1'b1);
    push_row('{OP_DROP, -5'sd1, 3'd0, 16'd4096, 1'b0, 4'd3}, FRAME_A, 1'b0, 1'b1, A_LOW3, 4'd3,
             1'b1);
    push_row('{OP_TRUNCATE, 5'sd5, 3'd0, 16'd4096, 1'b0, 4'd4}, FRAME_A, 1'b1, 1'b1, A_LOW4, 4'd4,
             1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table, reprogramming only when the settings change.
    foreach (frame_table[i]) begin
      row = frame_table[i];
      if (row.settings != live_settings) begin
        settle();
        program_settings(row.settings);
      end
      want = row.typed ? row.result : predict_frame(row.settings, row.samples, row.last);
      send_frame(row.samples, row.last, want);
    end

    // Random segments, each under fresh settings, some without any idling.
    beats_left = RANDOM_BEATS;
    while (beats_left > 0) begin
      seg = $urandom_range(8, 40);
      if (seg > beats_left) seg = beats_left;
      c = random_settings();
      settle();
      program_settings(c);
      steady = ($urandom_range(0, 3) == 0);
      repeat (seg) begin
        for (int i = 0; i < LANES; i++) x[i] = random_sample();
        lst = ($urandom_range(0, 7) == 0);
        send_frame(x, lst, predict_frame(live_settings, x, lst));
      end
      beats_left -= seg;
    end

    settle();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
src/acmo_pkg.sv
src/acmo_in_if.sv
src/acmo_out_if.sv
src/audio_channel_mix_op_unit.sv
sim/tb_top.sv
